@@ hw/rtl/lfv_pkg.sv @@
// ----------------------------------------------------------------------------
// lfv_pkg
// Shared constants, types and constant tables of the level follower.
// ----------------------------------------------------------------------------
`default_nettype none

package lfv_pkg;

  localparam int LEVEL_FRAC_BITS_DEF = 16;

  // configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_FLOOR       = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SENSITIVITY = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SMOOTHING   = 2'd2;

  localparam int ELAPSED_W = 20;
  localparam int SENS_W    = 16;
  localparam int STEPS_W   = 20;

  // steps in Q.16 = elapsed_us * 60 * 65536 / 1e6 = elapsed_us * 12288 / 3125
  localparam int STEP_NUM = 12288;
  localparam int STEP_DEN = 3125;
  localparam int STEP_MAX_I = 8 * 65536;
  localparam logic [STEPS_W-1:0] STEP_MAX = STEPS_W'(STEP_MAX_I);
  localparam logic [ELAPSED_W-1:0] STEP_SAT_US =
    ELAPSED_W'((STEP_MAX_I * STEP_DEN - 1) / STEP_NUM);
  localparam int STEP_RECIP_SH = 43;
  localparam logic [31:0] STEP_RECIP =
    32'(((64'd1 << STEP_RECIP_SH) + 64'(STEP_DEN) - 64'd1) / 64'(STEP_DEN));

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // classification of one word, produced by the front part
  typedef struct packed {
    logic        live;    // source present and above the floor
    logic        sat;     // elapsed time saturates the step count
    logic        nostep;  // no elapsed time
    logic [30:0] x;       // elapsed_us * STEP_NUM
  } cls_t;

  typedef logic [15:0][30:0] root_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] bt;
    v  = v_in;
    r  = '0;
    bt = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + bt) begin
        v = v - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  // successive square roots of 1/2 in Q.30
  function automatic root_tab_t build_roots();
    root_tab_t   t;
    logic [63:0] c;
    c    = isqrt64(64'd1 << 59);
    t[0] = c[30:0];
    for (int j = 1; j < 16; j++) begin
      c    = isqrt64(c << 30);
      t[j] = c[30:0];
    end
    return t;
  endfunction

  localparam root_tab_t ROOT_TAB = build_roots();

endpackage

`default_nettype wire

@@ hw/rtl/lfv_if.sv @@
// ----------------------------------------------------------------------------
// lfv_if
// Valid/ready channels of the level follower: measurement in, level out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfv_in_if #(
  parameter int LW = lfv_pkg::LEVEL_FRAC_BITS_DEF + 1
);
  logic                           valid;
  logic                           ready;
  logic                           source_present;
  logic [LW-1:0]                  meas_level;
  logic [lfv_pkg::ELAPSED_W-1:0]  elapsed_us;

  modport source (output valid, source_present, meas_level, elapsed_us, input ready);
  modport sink   (input valid, source_present, meas_level, elapsed_us, output ready);
endinterface

interface lfv_out_if #(
  parameter int LW = lfv_pkg::LEVEL_FRAC_BITS_DEF + 1
);
  logic          valid;
  logic          ready;
  logic [LW-1:0] smoothed_level;

  modport source (output valid, smoothed_level, input ready);
  modport sink   (input valid, smoothed_level, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lfv_front.sv @@
// ----------------------------------------------------------------------------
// lfv_front
// Classifies an incoming word: floor subtraction, target gating and the
// elapsed time prepared for the step count.
// ----------------------------------------------------------------------------
`default_nettype none

module lfv_front #(
  parameter int LEVEL_FRAC_BITS = lfv_pkg::LEVEL_FRAC_BITS_DEF
) (
  input  wire logic                              source_present,
  input  wire logic [LEVEL_FRAC_BITS:0]          meas_level,
  input  wire logic [lfv_pkg::ELAPSED_W-1:0]     elapsed_us,
  input  wire logic [LEVEL_FRAC_BITS:0]          floor_level,
  output      lfv_pkg::cls_t                     cls,
  output      logic [LEVEL_FRAC_BITS:0]          diff
);

  localparam int LW = LEVEL_FRAC_BITS + 1;
  localparam logic [LW-1:0] ONE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

  logic [LW-1:0] nf;
  logic [17:0]   e18;

  assign nf  = (floor_level > ONE) ? ONE : floor_level;
  assign e18 = elapsed_us[17:0];

  always_comb begin
    cls.live   = source_present && (meas_level > nf);
    cls.sat    = elapsed_us > lfv_pkg::STEP_SAT_US;
    cls.nostep = elapsed_us == '0;
    // times 12288 = times 3 shifted by 12
    cls.x      = 31'({e18, 13'b0}) + 31'({e18, 12'b0});
    diff       = meas_level - nf;
  end

endmodule

`default_nettype wire

@@ hw/rtl/lfv_queue.sv @@
// ----------------------------------------------------------------------------
// lfv_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module lfv_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output      logic         full,
  input  wire logic         pop,
  output      logic         nonempty,
  output      logic [W-1:0] dout
);

  logic [W-1:0] ent [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;

  assign full     = cnt == 2'd2;
  assign nonempty = cnt != 2'd0;
  assign dout     = ent[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lfv_exec.sv @@
// ----------------------------------------------------------------------------
// lfv_exec
// Back part: target, step count, power by log2/exp2 and the level update,
// all through one shared registered multiplier. Holds the kept level, a
// cached log of the base and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfv_exec #(
  parameter int LEVEL_FRAC_BITS = lfv_pkg::LEVEL_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  input  wire lfv_pkg::cls_t                 q_cls,
  input  wire logic [LEVEL_FRAC_BITS:0]      q_diff,
  output      logic                          q_pop,
  input  wire logic [lfv_pkg::SENS_W-1:0]    sensitivity,
  input  wire logic [LEVEL_FRAC_BITS:0]      smoothing,
  input  wire logic                          smooth_wr,
  output      logic                          res_valid,
  input  wire logic                          res_ready,
  output      logic [LEVEL_FRAC_BITS:0]      res_level
);

  localparam int F  = LEVEL_FRAC_BITS;
  localparam int LW = F + 1;
  localparam logic [LW-1:0] ONE   = {1'b1, {F{1'b0}}};
  localparam logic [LW-1:0] S_MIN = LW'(((1 << F) + 50) / 100);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TGT  = 4'd1;
  localparam logic [3:0] S_STEP = 4'd2;
  localparam logic [3:0] S_SCAP = 4'd3;
  localparam logic [3:0] S_NORM = 4'd4;
  localparam logic [3:0] S_LOG  = 4'd5;
  localparam logic [3:0] S_LOGF = 4'd6;
  localparam logic [3:0] S_NMUL = 4'd7;
  localparam logic [3:0] S_NCAP = 4'd8;
  localparam logic [3:0] S_EXP  = 4'd9;
  localparam logic [3:0] S_EXPF = 4'd10;
  localparam logic [3:0] S_UPD  = 4'd11;
  localparam logic [3:0] S_UCAP = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0]                  state;
  logic [3:0]                  cnt;
  lfv_pkg::cls_t               cls;
  logic [LW-1:0]               dreg;
  logic [LW-1:0]               tgt;
  logic [lfv_pkg::STEPS_W-1:0] steps;
  logic [LW-1:0]               alpha;
  logic [30:0]                 mn;
  logic [4:0]                  sh;
  logic [15:0]                 fr;
  logic [20:0]                 lval;
  logic                        lok;
  logic [15:0]                 fexp;
  logic                        kbig;
  logic [4:0]                  ksh;
  logic                        up;
  logic [LW-1:0]               level;
  logic [63:0]                 prod;

  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [LW-1:0] s_eff;
  logic [LW-1:0] b;
  logic [31:0]   pr;
  logic          sq_bit;
  logic [30:0]   mfix;
  logic [LW+7:0] tprod;
  logic [30:0]   pfin;
  logic [30:0]   pk;
  logic [30:0]   pshift;
  logic [LW-1:0] dlt;
  logic [LW:0]   nsum;
  logic [LW:0]   nxt;
  logic          out_load;

  assign s_eff  = (smoothing < S_MIN) ? S_MIN : ((smoothing > ONE) ? ONE : smoothing);
  assign b      = ONE - s_eff;
  assign pr     = prod[61:30];
  assign sq_bit = pr[31];
  assign mfix   = sq_bit ? pr[31:1] : pr[30:0];
  assign tprod  = prod[LW+15:8];
  assign pfin   = prod[60:30];
  assign pk     = kbig ? '0 : (pfin >> ksh);
  assign pshift = pk >> (30 - F);
  assign dlt    = prod[F +: LW];
  assign nsum   = {1'b0, level} + {1'b0, dlt};
  assign nxt    = up ? nsum : {1'b0, level - dlt};
  assign q_pop  = (state == S_IDLE) && q_valid;
  assign out_load = (state == S_OUT) && (!res_valid || res_ready);

  // operand selection of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_TGT: begin
        mul_a = 32'(dreg);
        mul_b = 32'(sensitivity);
      end
      S_STEP: begin
        mul_a = 32'(cls.x);
        mul_b = lfv_pkg::STEP_RECIP;
      end
      S_LOG: begin
        mul_a = (cnt == '0) ? 32'(mn) : 32'(mfix);
        mul_b = (cnt == '0) ? 32'(mn) : 32'(mfix);
      end
      S_NMUL: begin
        mul_a = 32'(steps);
        mul_b = 32'(lval);
      end
      S_EXP: begin
        mul_a = (cnt == '0) ? 32'(lfv_pkg::Q30_ONE) : 32'(pfin);
        mul_b = fexp[15] ? 32'(lfv_pkg::ROOT_TAB[cnt]) : 32'(lfv_pkg::Q30_ONE);
      end
      S_UPD: begin
        mul_a = (tgt >= level) ? 32'(tgt - level) : 32'(level - tgt);
        mul_b = 32'(alpha);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      lok   <= 1'b0;
      level <= '0;
    end else begin
      if (smooth_wr) begin
        lok <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cls   <= q_cls;
            dreg  <= q_diff;
            state <= S_TGT;
          end
        end
        S_TGT: begin
          state <= S_STEP;
        end
        S_STEP: begin
          if (!cls.live) begin
            tgt <= '0;
          end else if (tprod > (LW+8)'(ONE)) begin
            tgt <= ONE;
          end else begin
            tgt <= tprod[LW-1:0];
          end
          state <= S_SCAP;
        end
        S_SCAP: begin
          steps <= cls.sat ? lfv_pkg::STEP_MAX : prod[62:43];
          if (cls.nostep) begin
            alpha <= '0;
            state <= S_UPD;
          end else if (b == '0) begin
            alpha <= ONE;
            state <= S_UPD;
          end else if (lok) begin
            state <= S_NMUL;
          end else begin
            mn    <= 31'(b) << (30 - F);
            sh    <= '0;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (mn[30]) begin
            cnt   <= '0;
            state <= S_LOG;
          end else begin
            mn <= {mn[29:0], 1'b0};
            sh <= sh + 5'd1;
          end
        end
        S_LOG: begin
          if (cnt != '0) begin
            fr <= {fr[14:0], sq_bit};
          end
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            state <= S_LOGF;
          end
        end
        S_LOGF: begin
          lval  <= {sh, 16'b0} - {5'b0, fr[14:0], sq_bit};
          lok   <= 1'b1;
          state <= S_NMUL;
        end
        S_NMUL: begin
          state <= S_NCAP;
        end
        S_NCAP: begin
          fexp  <= prod[31:16];
          kbig  <= prod[39:32] >= 8'd31;
          ksh   <= prod[36:32];
          cnt   <= '0;
          state <= S_EXP;
        end
        S_EXP: begin
          fexp <= {fexp[14:0], 1'b0};
          cnt  <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            state <= S_EXPF;
          end
        end
        S_EXPF: begin
          alpha <= ONE - pshift[LW-1:0];
          state <= S_UPD;
        end
        S_UPD: begin
          up    <= tgt >= level;
          state <= S_UCAP;
        end
        S_UCAP: begin
          level <= (nxt > {1'b0, ONE}) ? ONE : nxt[LW-1:0];
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_level <= level;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/level_follower_variable_step_top.sv @@
// Path: a word with no elapsed time or a smoothing of one or more skips the log2/exp2
//   power; other words go through it, and the first of them after reset or a smoothing
//   write also refills the cached log2.
// Flow: the back part takes one word at a time through its shared multiplier;
//   a two-entry queue lets the front take words while the back is busy.
// Reset: synchronous, clears the queue, the kept level and the cached log2.
// ----------------------------------------------------------------------------
// level_follower_variable_step_top
// Smoothed level follower with a variable time step: configuration registers,
// front classification, queue and back execution.
// ----------------------------------------------------------------------------
`default_nettype none

module level_follower_variable_step_top #(
  parameter int LEVEL_FRAC_BITS = lfv_pkg::LEVEL_FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [lfv_pkg::REG_IDX_W-1:0]       cfg_idx,
  input  wire logic [((LEVEL_FRAC_BITS + 1 > lfv_pkg::SENS_W) ?
                      LEVEL_FRAC_BITS : lfv_pkg::SENS_W - 1):0] cfg_wdata,
  lfv_in_if.sink                                   items,
  lfv_out_if.source                                results
);

  localparam int F  = LEVEL_FRAC_BITS;
  localparam int LW = F + 1;
  localparam logic [LW-1:0] S_RESET = LW'(((1 << F) + 5) / 10);
  localparam int QW = $bits(lfv_pkg::cls_t) + LW;

  logic [LW-1:0]              floor_level;
  logic [lfv_pkg::SENS_W-1:0] sensitivity;
  logic [LW-1:0]              smoothing;
  logic                       smooth_wr;

  lfv_pkg::cls_t f_cls;
  logic [LW-1:0] f_diff;
  logic          q_full;
  logic          q_nonempty;
  logic          q_pop;
  logic          push;
  logic [QW-1:0] q_dout;

  assign smooth_wr = cfg_we && (cfg_idx == lfv_pkg::REG_SMOOTHING);

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_level <= '0;
      sensitivity <= lfv_pkg::SENS_W'(256);
      smoothing   <= S_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        lfv_pkg::REG_FLOOR:       floor_level <= cfg_wdata[LW-1:0];
        lfv_pkg::REG_SENSITIVITY: sensitivity <= cfg_wdata[lfv_pkg::SENS_W-1:0];
        lfv_pkg::REG_SMOOTHING:   smoothing   <= cfg_wdata[LW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign items.ready = !q_full;
  assign push        = items.valid && !q_full;

  lfv_front #(.LEVEL_FRAC_BITS(F)) u_front (
    .source_present (items.source_present),
    .meas_level     (items.meas_level),
    .elapsed_us     (items.elapsed_us),
    .floor_level    (floor_level),
    .cls            (f_cls),
    .diff           (f_diff)
  );

  lfv_queue #(.W(QW)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din      ({f_cls, f_diff}),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .dout     (q_dout)
  );

  lfv_exec #(.LEVEL_FRAC_BITS(F)) u_exec (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_nonempty),
    .q_cls       (q_dout[QW-1:LW]),
    .q_diff      (q_dout[LW-1:0]),
    .q_pop       (q_pop),
    .sensitivity (sensitivity),
    .smoothing   (smoothing),
    .smooth_wr   (smooth_wr),
    .res_valid   (results.valid),
    .res_ready   (results.ready),
    .res_level   (results.smoothed_level)
  );

endmodule

`default_nettype wire

@@ hw/rtl/lfv_checker.sv @@
// ----------------------------------------------------------------------------
// lfv_checker
// Port-level checks of the level follower, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lfv_checker #(
  parameter int LEVEL_FRAC_BITS = lfv_pkg::LEVEL_FRAC_BITS_DEF
) (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_ready,
  input wire logic                     res_valid,
  input wire logic                     res_ready,
  input wire logic [LEVEL_FRAC_BITS:0] res_level
);

  localparam logic [LEVEL_FRAC_BITS:0] ONE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

  // the level never leaves 0..1
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_level <= ONE)
    else $error("smoothed level above one");

  // a waiting word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_level))
    else $error("output word changed while stalled");

  // reset empties both sides
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid && in_ready)
    else $error("not empty after reset");

endmodule

bind level_follower_variable_step_top lfv_checker #(
  .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
) u_lfv_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (items.ready),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_level (results.smoothed_level)
);

`default_nettype wire
